// File: src/region_mean_nearest_palette_match_assert.svh
// Assertion macros for the palette matcher RTL, included by rmnp_back.
`ifndef REGION_MEAN_NEAREST_PALETTE_MATCH_ASSERT_SVH
`define REGION_MEAN_NEAREST_PALETTE_MATCH_ASSERT_SVH

// Checks an implication that holds in the same cycle.
`define RMNP_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Checks an implication that holds in the next cycle.
`define RMNP_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: src/rmnp_pkg.sv
// ----------------------------------------------------------------------------
// rmnp_pkg
// Types and constants shared by the region mean palette matcher.
// ----------------------------------------------------------------------------
package rmnp_pkg;

  localparam int SumW       = 28;
  localparam int PixW       = 8;
  localparam int EntryW     = 16;
  localparam int IdxInW     = 10;
  localparam int TilesW     = 11;
  localparam int CountW     = 21;
  localparam int OutDistW   = 10;
  localparam int DistMax    = 1023;
  localparam int InDataW    = 88;
  localparam int OutDataW   = 24;
  localparam int CfgDataW   = 21;
  localparam int MaxTilesDef = 1024;
  localparam int FracDef    = 8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef enum logic {
    REG_TILES = 1'b0,
    REG_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [SumW-1:0] blue;
    logic [SumW-1:0] green;
    logic [SumW-1:0] red;
  } sums_t;

  typedef struct packed {
    logic              en;
    logic [IdxInW-1:0] idx;
    logic [EntryW-1:0] blue;
    logic [EntryW-1:0] green;
    logic [EntryW-1:0] red;
  } pal_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: src/rmnp_fifo.sv
// ----------------------------------------------------------------------------
// rmnp_fifo
// Two-entry queue of region channel sums between front and back.
// ----------------------------------------------------------------------------
module rmnp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rmnp_pkg::sums_t  push_data_i,
  input  logic             pop_i,
  output rmnp_pkg::sums_t  pop_data_o,
  output rmnp_pkg::fifo_stat_t stat_o
);
  import rmnp_pkg::*;

  sums_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

// File: src/rmnp_front.sv
// ----------------------------------------------------------------------------
// rmnp_front
// Accepts items, accumulates region pixels and routes palette loads.
// ----------------------------------------------------------------------------
module rmnp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rmnp_pkg::InDataW-1:0]  in_data_i,
  input  logic                          in_op_i,
  input  logic                          in_last_i,
  input  logic                          back_idle_i,
  input  rmnp_pkg::fifo_stat_t          fifo_stat_i,
  output logic                          push_o,
  output rmnp_pkg::sums_t               push_data_o,
  output rmnp_pkg::pal_wr_t             pal_wr_o
);
  import rmnp_pkg::*;

  sums_t          sums_q, sums_d;
  logic           accept;
  logic [SumW:0]  sb, sg, sr;
  localparam logic [SumW:0] SumMax = {1'b0, {SumW{1'b1}}};

  // Loads wait until every earlier region has finished its search.
  always_comb begin
    unique case (op_e'(in_op_i))
      OP_LOAD:  in_ready_o = back_idle_i && fifo_stat_i.empty;
      OP_PIXEL: in_ready_o = !in_last_i || !fifo_stat_i.full;
      default:  in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    sb = {1'b0, sums_q.blue}  + (SumW+1)'(in_data_i[65:58]);
    sg = {1'b0, sums_q.green} + (SumW+1)'(in_data_i[73:66]);
    sr = {1'b0, sums_q.red}   + (SumW+1)'(in_data_i[81:74]);
    push_data_o.blue  = (sb > SumMax) ? SumMax[SumW-1:0] : sb[SumW-1:0];
    push_data_o.green = (sg > SumMax) ? SumMax[SumW-1:0] : sg[SumW-1:0];
    push_data_o.red   = (sr > SumMax) ? SumMax[SumW-1:0] : sr[SumW-1:0];
    push_o = accept && (in_op_i == OP_PIXEL) && in_last_i;
    sums_d = sums_q;
    if (accept && (in_op_i == OP_PIXEL)) begin
      sums_d = in_last_i ? '0 : push_data_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sums_q <= '0;
    else sums_q <= sums_d;
  end

  assign pal_wr_o.en    = accept && (in_op_i == OP_LOAD);
  assign pal_wr_o.idx   = in_data_i[9:0];
  assign pal_wr_o.blue  = in_data_i[25:10];
  assign pal_wr_o.green = in_data_i[41:26];
  assign pal_wr_o.red   = in_data_i[57:42];

endmodule

// File: src/rmnp_back.sv
// ----------------------------------------------------------------------------
// rmnp_back
// Divides region sums into means, then scans the palette for the nearest tile.
// ----------------------------------------------------------------------------
module rmnp_back #(
  parameter int MAX_TILES      = rmnp_pkg::MaxTilesDef,
  parameter int MEAN_FRAC_BITS = rmnp_pkg::FracDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rmnp_pkg::TilesW-1:0]   tiles_in_use_i,
  input  logic [rmnp_pkg::CountW-1:0]   pixel_count_i,
  input  rmnp_pkg::pal_wr_t             pal_wr_i,
  input  rmnp_pkg::fifo_stat_t          fifo_stat_i,
  input  rmnp_pkg::sums_t               fifo_data_i,
  output logic                          pop_o,
  output logic                          idle_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmnp_pkg::OutDataW-1:0] out_data_o
);
  import rmnp_pkg::*;

  localparam int F     = MEAN_FRAC_BITS;
  localparam int IdxW  = (MAX_TILES > 2) ? $clog2(MAX_TILES) : 1;
  localparam int CntW  = $clog2(MAX_TILES + 1);
  localparam int TW    = (CntW > TilesW) ? CntW : TilesW;
  localparam int MW    = 8 + F;
  localparam int NW    = SumW + F;
  localparam int DCW   = $clog2(NW + 1);
  localparam int DW    = (MW > EntryW) ? MW : EntryW;
  localparam int DSW   = DW - F + 2;
  localparam int XW    = IdxW + IdxInW;
  localparam logic [NW-1:0] MeanMaxN = NW'((64'd256 << F) - 64'd1);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_SCAN, ST_OUT} state_e;

  state_e               state_q;
  logic [DCW-1:0]       div_cnt_q;
  logic [NW-1:0]        dvd_q [3];
  logic [CountW-1:0]    rem_q [3];
  logic [MW-1:0]        mean_q [3];
  logic [CountW-1:0]    divisor_q;
  logic [CountW:0]      trial [3];
  logic [NW-1:0]        sums_ext [3];
  logic [TW-1:0]        tiles_eff_q, tiles_raw, max_t;
  logic [TW-1:0]        j_q;
  logic                 issue;
  logic                 v1_q, v2_q, first_q;
  logic [TW-1:0]        idx1_q, idx2_q, best_idx_q;
  logic [DSW-1:0]       d2_q, best_d_q, dsum;
  logic [DW-1:0]        ma, pa;
  logic [DW-1:0]        adiff [3];
  logic [EntryW*3-1:0]  mem_q [MAX_TILES];
  logic [EntryW*3-1:0]  rd_q;
  logic [XW-1:0]        wr_ext;
  logic [XW-1:0]        best_ext;
  logic                 wr_ok;
  logic                 out_valid_q;
  logic [IdxInW-1:0]    out_tile_q;
  logic [OutDistW-1:0]  out_dist_q;

  assign wr_ext = {{IdxW{1'b0}}, pal_wr_i.idx};
  assign wr_ok  = pal_wr_i.en && (wr_ext < XW'(MAX_TILES));

  always_ff @(posedge clk_i) begin
    if (wr_ok) mem_q[wr_ext[IdxW-1:0]] <= {pal_wr_i.red, pal_wr_i.green, pal_wr_i.blue};
    if (issue) rd_q <= mem_q[j_q[IdxW-1:0]];
  end

  assign tiles_raw = TW'(tiles_in_use_i);
  assign max_t     = TW'(MAX_TILES);
  assign sums_ext[0] = NW'(fifo_data_i.blue) << F;
  assign sums_ext[1] = NW'(fifo_data_i.green) << F;
  assign sums_ext[2] = NW'(fifo_data_i.red) << F;
  assign pop_o  = (state_q == ST_IDLE) && !fifo_stat_i.empty;
  assign idle_o = (state_q == ST_IDLE);
  assign issue  = (state_q == ST_SCAN) && (j_q < tiles_eff_q);

  // Restoring division, one quotient bit per cycle in each channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial[c] = {rem_q[c], dvd_q[c][NW-1]};
    end
  end

  // Per-channel distance of the entry read in the previous cycle.
  always_comb begin
    dsum = '0;
    for (int c = 0; c < 3; c++) begin
      ma = DW'(mean_q[c]);
      pa = DW'(rd_q[c*EntryW +: EntryW]);
      adiff[c] = (ma > pa) ? (ma - pa) : (pa - ma);
      dsum = dsum + DSW'(adiff[c] >> F);
    end
  end

  assign best_ext = {{IdxInW{1'b0}}, best_idx_q[IdxW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      v1_q <= issue;
      v2_q <= v1_q;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            for (int c = 0; c < 3; c++) begin
              dvd_q[c] <= sums_ext[c];
              rem_q[c] <= '0;
            end
            divisor_q <= (pixel_count_i == '0) ? CountW'(1) : pixel_count_i;
            if (tiles_raw == '0) tiles_eff_q <= TW'(1);
            else if (tiles_raw > max_t) tiles_eff_q <= max_t;
            else tiles_eff_q <= tiles_raw;
            div_cnt_q <= DCW'(NW);
            state_q   <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int c = 0; c < 3; c++) begin
            if (trial[c] >= {1'b0, divisor_q}) begin
              rem_q[c] <= CountW'(trial[c] - {1'b0, divisor_q});
              dvd_q[c] <= {dvd_q[c][NW-2:0], 1'b1};
            end else begin
              rem_q[c] <= trial[c][CountW-1:0];
              dvd_q[c] <= {dvd_q[c][NW-2:0], 1'b0};
            end
          end
          div_cnt_q <= div_cnt_q - DCW'(1);
          if (div_cnt_q == DCW'(1)) begin
            state_q <= ST_SCAN;
            j_q     <= '0;
            first_q <= 1'b1;
          end
        end
        ST_SCAN: begin
          // Once the divide is done, the shift registers hold the quotients.
          if (j_q == '0 && first_q && !v1_q && !v2_q) begin
            for (int c = 0; c < 3; c++) begin
              mean_q[c] <= (dvd_q[c] > MeanMaxN) ? MeanMaxN[MW-1:0] : dvd_q[c][MW-1:0];
            end
          end
          if (issue) begin
            j_q    <= j_q + TW'(1);
            idx1_q <= j_q;
          end
          if (v1_q) begin
            d2_q   <= dsum;
            idx2_q <= idx1_q;
          end
          if (v2_q && (first_q || d2_q < best_d_q)) begin
            best_d_q   <= d2_q;
            best_idx_q <= idx2_q;
            first_q    <= 1'b0;
          end
          if (!issue && !v1_q && !v2_q && (j_q == tiles_eff_q)) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_tile_q  <= best_ext[IdxInW-1:0];
            out_dist_q  <= (best_d_q > DSW'(DistMax)) ? OutDistW'(DistMax)
                                                      : best_d_q[OutDistW-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The first palette read goes out in the same cycle that registers the means.
  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'b0, out_dist_q, out_tile_q};

  `include "region_mean_nearest_palette_match_assert.svh"

  `RMNP_ASSERT_NOW(a_wr_only_idle, pal_wr_i.en, state_q == ST_IDLE && fifo_stat_i.empty, "palette written during a search")
  `RMNP_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, j_q <= tiles_eff_q, "scan ran past the tile count")
  `RMNP_ASSERT_NEXT(a_pop_to_div, pop_o, state_q == ST_DIV, "popped region did not start dividing")

endmodule

// File: src/region_mean_nearest_palette_match.sv
// ----------------------------------------------------------------------------
// region_mean_nearest_palette_match
// Photo-mosaic tile chooser: region mean color, nearest palette entry by L1.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Contents
//  s_axis    in         tvalid/tready        tdata: palette entry or pixel,
//                                            tuser: opcode, tlast: last pixel
//  m_axis    out        tvalid/tready        tdata: best tile and distance
//  cfg       in         cfg_we_i             tiles in use, pixels per region
//
//  Pixels and loads are taken one per cycle unless stalled. A last pixel
//  queues its sums (two regions deep; it stalls while the queue is full)
//  and accumulation of the next region goes on at once. Each region is
//  popped, its means divided out and the palette scanned, the scan bounded
//  by the single read port of the palette memory; a stalled m_axis delays the handover.
//  A load stalls until all queued regions have been searched.
//  Reset clears sums, queue and control; the palette is undefined until loaded.
// ----------------------------------------------------------------------------
module region_mean_nearest_palette_match #(
  parameter int MAX_TILES      = rmnp_pkg::MaxTilesDef,
  parameter int MEAN_FRAC_BITS = rmnp_pkg::FracDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index, entry_blue, entry_green, entry_red,
  // pixel_blue, pixel_green, pixel_red, zero fill
  input  logic [rmnp_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // best_tile, best_distance, zero fill
  output logic [rmnp_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [rmnp_pkg::CfgDataW-1:0] cfg_data_i
);
  import rmnp_pkg::*;

  logic [TilesW-1:0] tiles_q;
  logic [CountW-1:0] count_q;
  logic              push, pop, back_idle;
  sums_t             push_data, pop_data;
  fifo_stat_t        fstat;
  pal_wr_t           pal_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tiles_q <= TilesW'(1);
      count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_TILES: tiles_q <= cfg_data_i[TilesW-1:0];
        REG_COUNT: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rmnp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .back_idle_i (back_idle),
    .fifo_stat_i (fstat),
    .push_o      (push),
    .push_data_o (push_data),
    .pal_wr_o    (pal_wr)
  );

  rmnp_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fstat)
  );

  rmnp_back #(
    .MAX_TILES      (MAX_TILES),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .tiles_in_use_i (tiles_q),
    .pixel_count_i  (count_q),
    .pal_wr_i       (pal_wr),
    .fifo_stat_i    (fstat),
    .fifo_data_i    (pop_data),
    .pop_o          (pop),
    .idle_o         (back_idle),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

// File: test/region_mean_nearest_palette_match_test.sv
// ----------------------------------------------------------------------------
// region_mean_nearest_palette_match_test
// Streams palette loads and region pixels into the tile chooser, predicts each
// region's nearest palette entry and distance, and compares every output
// transaction against the prediction, under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module region_mean_nearest_palette_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmnp_pkg::*;

  localparam int  NumTiles   = 1024;
  localparam int  FracBits   = 8;
  localparam int  SettleWait = 1200;
  localparam int  CycleLimit = 2000000;
  localparam logic [27:0] SumSat  = '1;
  localparam int  MeanSat    = (256 << FracBits) - 1;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    op_e               op;
    logic [9:0]        idx;
    logic [15:0]       eb, eg, er;
    logic [7:0]        pb, pg, pr;
    logic              last;
    reg_e              reg_sel;
    logic [20:0]       reg_val;
    logic              known;
    logic [9:0]        tile;
    logic [9:0]        best_dist;
  } row_t;

  typedef struct packed {
    logic [9:0] tile;
    logic [9:0] best_dist;
  } match_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic                cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;

  region_mean_nearest_palette_match dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state.
  logic [15:0] pal_mean [NumTiles][3];
  bit          pal_written [NumTiles];
  logic [27:0] chan_sum [3];
  logic [10:0] tiles_reg;
  logic [20:0] count_reg;

  match_t      match_q [$];
  int          errors;
  int          cycles;
  int          rx_stall;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int draw_idle();
    if (calm) return 0;
    return $urandom_range(0, 10);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // Advances the predictor by one accepted item; returns 1 when a match is due.
  function automatic bit predict_match(row_t it, output match_t res);
    logic [7:0]  pix [3];
    logic [28:0] acc;
    longint      divisor, mean [3], d, best_d;
    int          span, best;
    res = '0;
    if (it.op == OP_LOAD) begin
      pal_mean[it.idx][0] = it.eb;
      pal_mean[it.idx][1] = it.eg;
      pal_mean[it.idx][2] = it.er;
      pal_written[it.idx] = 1'b1;
      return 1'b0;
    end
    pix[0] = it.pb; pix[1] = it.pg; pix[2] = it.pr;
    for (int c = 0; c < 3; c++) begin
      acc = chan_sum[c] + pix[c];
      chan_sum[c] = (acc > SumSat) ? SumSat : acc[27:0];
    end
    if (!it.last) return 1'b0;
    divisor = (count_reg == 0) ? 1 : count_reg;
    span = (tiles_reg == 0) ? 1 : ((tiles_reg > NumTiles) ? NumTiles : tiles_reg);
    for (int c = 0; c < 3; c++) begin
      mean[c] = (longint'(chan_sum[c]) << FracBits) / divisor;
      if (mean[c] > MeanSat) mean[c] = MeanSat;
    end
    best = 0;
    best_d = 0;
    for (int j = 0; j < span; j++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        if (mean[c] > pal_mean[j][c]) d += (mean[c] - pal_mean[j][c]) >> FracBits;
        else                          d += (pal_mean[j][c] - mean[c]) >> FracBits;
      end
      if (j == 0 || d < best_d) begin
        best_d = d;
        best = j;
      end
    end
    res.tile = best[9:0];
    res.best_dist = (best_d > DistMax) ? 10'(DistMax) : best_d[9:0];
    for (int c = 0; c < 3; c++) chan_sum[c] = '0;
    return 1'b1;
  endfunction

  // Drives one item after a random gap and waits until it is accepted.
  task automatic send(row_t it);
    int     gap;
    match_t res;
    gap = draw_idle();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {6'b0, it.pr, it.pg, it.pb, it.er, it.eg, it.eb, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_match(it, res)) begin
      if (it.known) begin
        res.tile = it.tile;
        res.best_dist = it.best_dist;
      end
      match_q.insert(match_q.size(), res);
    end
  endtask

  // Drains the block so a register may be written safely.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e sel, logic [20:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= sel;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (sel == REG_TILES) tiles_reg = val[10:0];
    else                  count_reg = val;
  endtask

  function automatic row_t ld(int idx, int b, int g, int r);
    row_t it;
    it = '{kind: ROW_ITEM, op: OP_LOAD, idx: 10'(idx), eb: 16'(b), eg: 16'(g),
           er: 16'(r), pb: 8'h5a, pg: 8'ha5, pr: 8'hff, last: 1'b1,
           reg_sel: REG_TILES, reg_val: '0, known: 1'b0, tile: '0, best_dist: '0};
    return it;
  endfunction

  function automatic row_t px(int b, int g, int r, bit last);
    row_t it;
    it = ld(0, 0, 0, 0);
    it.op = OP_PIXEL;
    it.pb = 8'(b); it.pg = 8'(g); it.pr = 8'(r);
    it.last = last;
    return it;
  endfunction

  function automatic row_t pxk(int b, int g, int r, int tile, int best_dist);
    row_t it;
    it = px(b, g, r, 1'b1);
    it.known = 1'b1;
    it.tile = 10'(tile);
    it.best_dist = 10'(best_dist);
    return it;
  endfunction

  function automatic row_t cf(reg_e sel, int val);
    row_t it;
    it = ld(0, 0, 0, 0);
    it.kind = ROW_CFG;
    it.reg_sel = sel;
    it.reg_val = 21'(val);
    return it;
  endfunction

  function automatic logic [15:0] rand_mean();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return {8'($urandom_range(0, 255)), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Loads every entry that the coming tile count will search but that is still empty.
  task automatic fill_palette(int span);
    for (int j = 0; j < span; j++)
      if (!pal_written[j]) send(ld(j, rand_mean(), rand_mean(), rand_mean()));
  endtask

  task automatic set_mode(int tiles, int count);
    int span;
    span = (tiles == 0) ? 1 : ((tiles > NumTiles) ? NumTiles : tiles);
    fill_palette(span);
    write_reg(REG_TILES, 21'(tiles));
    write_reg(REG_COUNT, 21'(count));
  endtask

  // Mostly regions of exactly the configured size, some of one to six pixels, and
  // only such ones when that size is above six, with palette rewrites mixed in.
  task automatic run_regions(int n);
    int left, per_region;
    per_region = (count_reg == 0) ? 1 : ((count_reg > 6) ? 0 : count_reg);
    left = 0;
    for (int k = 0; k < n || left != 0; k++) begin
      if (k < n && $urandom_range(0, 7) == 0) begin
        send(ld($urandom_range(0, NumTiles - 1), rand_mean(), rand_mean(), rand_mean()));
      end else begin
        if (left == 0)
          left = (per_region == 0 || $urandom_range(0, 4) == 0) ?
                 $urandom_range(1, 6) : per_region;
        send(px(rand_pix(), rand_pix(), rand_pix(), left == 1));
        left--;
      end
    end
  endtask

  initial begin
    row_t steps [$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = 1'b0;
    cfg_data_i    = '0;
    errors = 0;
    cycles = 0;
    calm   = 1'b0;
    tiles_reg = 11'd1;
    count_reg = 21'd1;
    for (int c = 0; c < 3; c++) chan_sum[c] = '0;
    for (int j = 0; j < NumTiles; j++) begin
      pal_written[j] = 1'b0;
      for (int c = 0; c < 3; c++) pal_mean[j][c] = '0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows, starting from one tile and one pixel per region after reset.
    steps = '{
      ld(0, 0, 0, 0),
      pxk(0, 0, 0, 0, 0),
      ld(0, 'hffff, 'hffff, 'hffff),
      pxk(255, 255, 255, 0, 0),
      pxk(0, 0, 0, 0, 765),
      px(255, 255, 255, 1'b0),
      pxk(255, 255, 255, 0, 0),                // mean saturates at full scale
      ld(1023, 'hffff, 0, 'hffff),
      cf(REG_TILES, 4),
      ld(1, 'h8000, 'h8000, 'h8000),
      ld(2, 'h8000, 'h8000, 'h8000),
      ld(3, 'h4000, 'h4000, 'h4000),
      pxk(128, 128, 128, 1, 0),                // tie goes to the lower index
      cf(REG_COUNT, 0),
      pxk(64, 64, 64, 3, 0),                   // zero pixel count divides by one
      cf(REG_COUNT, 2),
      px(10, 20, 30, 1'b0),
      px(11, 21, 31, 1'b1),
      px(200, 0, 255, 1'b1),
      ld(5, 'h1234, 'h5678, 'h9abc),           // loads give no result
      px(1, 2, 3, 1'b1)
    };
    foreach (steps[i]) begin
      if (steps[i].kind == ROW_CFG) write_reg(steps[i].reg_sel, steps[i].reg_val);
      else                          send(steps[i]);
    end

    set_mode(8, 3);
    run_regions(60);
    calm = 1'b1;
    set_mode(1, 0);
    run_regions(40);
    calm = 1'b0;
    set_mode(37, 1);
    run_regions(60);
    set_mode(40, 5);
    run_regions(30);
    set_mode(0, 2097151);
    run_regions(30);
    set_mode(48, 1048576);
    run_regions(20);
    set_mode(16, 2);
    run_regions(80);

    settle();
    if (errors == 0 && match_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: random back-pressure after each transaction.
  initial begin
    m_axis_tready = 1'b0;
    rx_stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= rst_ni;
      end
    end
  end

  always @(posedge clk_i) begin
    match_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (match_q.size() == 0) begin
        report("unexpected result, tile", m_axis_tdata[9:0], 0);
      end else begin
        want = match_q.pop_front();
        if (m_axis_tdata[9:0] !== want.tile) report("best_tile", m_axis_tdata[9:0], want.tile);
        if (m_axis_tdata[19:10] !== want.best_dist)
          report("best_distance", m_axis_tdata[19:10], want.best_dist);
      end
      rx_stall = draw_idle();
    end
  end

endmodule
